>>> rtl/tgr_pkg.sv
// Shared constants, types and colour decode for the text glyph row renderer.
package tgr_pkg;

  // Character cell geometry and font store size
  localparam int unsigned GLYPH_LINES   = 16;
  localparam int unsigned GLYPH_COLUMNS = 8;
  localparam int unsigned GLYPH_COUNT   = 128;
  localparam int unsigned STORE_DEPTH   = GLYPH_COUNT * GLYPH_LINES;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned CURSOR_HEIGHT = 4;

  localparam logic [23:0] CURSOR_GREY  = 24'h7F7F7F;
  localparam logic [7:0]  LEVEL_BRIGHT = 8'hFF;
  localparam logic [7:0]  LEVEL_NORMAL = 8'h7F;

  // Item operation codes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

  // One classified render command, carried from front to back
  typedef struct packed {
    logic [7:0] pattern;
    logic [3:0] fg_code;
    logic [3:0] bg_code;
    logic       grey;
  } cmd_t;

  // Expand a 4-bit colour code into 24-bit RGB
  function automatic logic [23:0] colour_of(input logic [3:0] code);
    logic [7:0] level;
    level = code[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
    colour_of = {code[2] ? level : 8'h00,
                 code[1] ? level : 8'h00,
                 code[0] ? level : 8'h00};
  endfunction

endpackage

>>> rtl/tgr_in_if.sv
// Input channel: load and render transactions.
interface tgr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_code;
  logic [3:0] glyph_line;
  logic [7:0] font_bits;
  logic [3:0] fg_code;
  logic [3:0] bg_code;
  logic       cursor_cell;

  modport source (output valid, operation, char_code, glyph_line, font_bits,
                  fg_code, bg_code, cursor_cell, input ready);
  modport sink   (input valid, operation, char_code, glyph_line, font_bits,
                  fg_code, bg_code, cursor_cell, output ready);
endinterface

>>> rtl/tgr_out_if.sv
// Output channel: one pixel per transaction.
interface tgr_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;
  logic [2:0]  pixel_column;
  logic        last_pixel;

  modport source (output valid, pixel_rgb, pixel_column, last_pixel, input ready);
  modport sink   (input valid, pixel_rgb, pixel_column, last_pixel, output ready);
endinterface

>>> rtl/tgr_front.sv
// Front end: accepts transactions, owns the font store, classifies renders.
module tgr_front import tgr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tgr_in_if.sink       in_i,
  output logic         push_o,
  output cmd_t         push_cmd_o,
  input  logic         full_i
);

  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rdata_q;
  logic              s1_valid_q, s1_valid_d;
  logic [3:0]        fg_q, bg_q;
  logic              grey_q, in_range_q;

  logic              accept, is_render, in_range, grey;
  logic [ADDR_W-1:0] addr;
  logic [5:0]        line_w;

  // Classify the incoming transaction
  always_comb begin
    line_w    = {2'b00, in_i.glyph_line};
    in_range  = ({1'b0, in_i.char_code} < 9'(GLYPH_COUNT)) &&
                (line_w < 6'(GLYPH_LINES));
    addr      = ADDR_W'(32'(in_i.char_code) * GLYPH_LINES + 32'(in_i.glyph_line));
    grey      = in_i.cursor_cell && (line_w < 6'(GLYPH_LINES)) &&
                (line_w + 6'(CURSOR_HEIGHT) >= 6'(GLYPH_LINES));
    is_render = (in_i.operation == OP_RENDER);
  end

  assign in_i.ready = !s1_valid_q || !full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Font store: write on load, registered read on render
  always_ff @(posedge clk_i) begin
    if (accept && !is_render && in_range) begin
      mem[addr] <= in_i.font_bits;
    end
    if (accept && is_render && in_range) begin
      rdata_q <= mem[addr];
    end
  end

  // Hold the render stage until the queue takes it
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept && is_render) begin
      s1_valid_d = 1'b1;
    end else if (s1_valid_q && !full_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_render) begin
      fg_q       <= in_i.fg_code;
      bg_q       <= in_i.bg_code;
      grey_q     <= grey;
      in_range_q <= in_range;
    end
  end

  // Blank out-of-range glyphs
  assign push_o             = s1_valid_q;
  assign push_cmd_o.pattern = in_range_q ? rdata_q : 8'h00;
  assign push_cmd_o.fg_code = fg_q;
  assign push_cmd_o.bg_code = bg_q;
  assign push_cmd_o.grey    = grey_q;

endmodule

>>> rtl/tgr_queue.sv
// Two-entry command queue between front and back.
module tgr_queue import tgr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/tgr_back.sv
// Back end: walks the glyph columns of the head command into pixels.
module tgr_back import tgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  cmd_t     head_i,
  output logic     pop_o,
  tgr_out_if.source out_o
);

  logic [2:0]  col_q;
  logic        out_valid_q;
  logic [23:0] rgb_q;
  logic [2:0]  out_col_q;
  logic        last_q;

  logic        advance, emit, last;
  logic [23:0] rgb;

  assign advance = !out_valid_q || out_o.ready;
  assign emit    = advance && !empty_i;
  assign last    = (col_q == 3'(GLYPH_COLUMNS - 1));
  assign pop_o   = emit && last;

  // Pick the pixel colour, leftmost pattern bit first
  always_comb begin
    if (head_i.grey) begin
      rgb = CURSOR_GREY;
    end else if (head_i.pattern[3'd7 - col_q]) begin
      rgb = colour_of(head_i.fg_code);
    end else begin
      rgb = colour_of(head_i.bg_code);
    end
  end

  // Column counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        col_q <= last ? 3'd0 : col_q + 3'd1;
      end
      if (advance) begin
        out_valid_q <= !empty_i;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      rgb_q     <= rgb;
      out_col_q <= col_q;
      last_q    <= last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_rgb    = rgb_q;
  assign out_o.pixel_column = out_col_q;
  assign out_o.last_pixel   = last_q;

endmodule

>>> rtl/text_glyph_row_renderer.sv
// A render passes through the front stage register, the queue and the output register before its first pixel is valid.
// One pixel per cycle while a command waits and the sink is ready; the column counter walks each render's columns;
// a load produces no pixel.
// The font store read port is registered; a two-entry queue decouples front/back.
// Reset clears the queue, the column counter and all valid flags at once;
// the font store is not cleared and holds nothing defined until loaded.
module text_glyph_row_renderer import tgr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tgr_in_if.sink    in_i,
  tgr_out_if.source out_o
);

  logic push, full, pop, empty;
  cmd_t push_cmd, head;

  tgr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  tgr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  tgr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> tb/sv/tb_text_glyph_row_renderer.sv
// Testbench for the text glyph row renderer: directed table, random items, line predictor.
module tb_text_glyph_row_renderer;
  timeunit 1ns;
  timeprecision 1ps;
  import tgr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 76;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned TABLE_ROWS   = 24;

  // One input transaction
  typedef struct packed {
    op_e        op;
    logic [7:0] code;
    logic [3:0] line;
    logic [7:0] bits;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       cursor;
  } glyph_item_t;

  // One output transaction
  typedef struct packed {
    logic [23:0] rgb;
    logic [2:0]  column;
    logic        last;
  } pixel_t;

  // Directed row: when solid is set, every pixel of the line must be solid_rgb
  typedef struct packed {
    glyph_item_t item;
    logic        solid;
    logic [23:0] solid_rgb;
  } table_row_t;

  logic clk_i;
  logic rst_ni;

  tgr_in_if  in_bus ();
  tgr_out_if out_bus ();

  text_glyph_row_renderer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Predictor state: font copy, which cells hold defined data, pixels in flight
  logic [7:0]  font_copy [STORE_DEPTH];
  bit          cell_loaded [STORE_DEPTH];
  int unsigned loaded_cells [$];
  pixel_t      pending_pixels [$];
  int unsigned mismatch_count;

  // Shared pacing controls
  bit calm;
  bit hold_request;

  table_row_t glyph_table [TABLE_ROWS] = '{
    '{'{OP_LOAD,   8'd0,   4'd0,  8'hFF, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd0,   4'd0,  8'h00, 4'hF, 4'h0, 1'b0}, 1'b1, 24'hFFFFFF},
    '{'{OP_LOAD,   8'd0,   4'd1,  8'h00, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd0,   4'd1,  8'h00, 4'hF, 4'h0, 1'b0}, 1'b1, 24'h000000},
    '{'{OP_LOAD,   8'd127, 4'd15, 8'hA5, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd127, 4'd15, 8'h00, 4'h8, 4'h7, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd127, 4'd15, 8'h00, 4'hF, 4'h0, 1'b1}, 1'b1, 24'h7F7F7F},
    '{'{OP_LOAD,   8'd127, 4'd12, 8'h3C, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd127, 4'd12, 8'h00, 4'h1, 4'h2, 1'b1}, 1'b1, 24'h7F7F7F},
    '{'{OP_LOAD,   8'd127, 4'd11, 8'h81, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd127, 4'd11, 8'h00, 4'hC, 4'h1, 1'b1}, 1'b0, 24'h000000},
    '{'{OP_LOAD,   8'd128, 4'd0,  8'h55, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd0,   4'd0,  8'h00, 4'hF, 4'h0, 1'b0}, 1'b1, 24'hFFFFFF},
    '{'{OP_LOAD,   8'd255, 4'd15, 8'h00, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd127, 4'd15, 8'h00, 4'hA, 4'h5, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd128, 4'd3,  8'h00, 4'h3, 4'h9, 1'b0}, 1'b1, 24'h0000FF},
    '{'{OP_RENDER, 8'd255, 4'd15, 8'hFF, 4'hF, 4'h6, 1'b1}, 1'b1, 24'h7F7F7F},
    '{'{OP_RENDER, 8'd200, 4'd0,  8'h00, 4'hF, 4'hF, 1'b0}, 1'b1, 24'hFFFFFF},
    '{'{OP_LOAD,   8'd65,  4'd7,  8'h80, 4'hF, 4'hF, 1'b1}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd65,  4'd7,  8'h00, 4'hE, 4'h4, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_LOAD,   8'd65,  4'd8,  8'h01, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd65,  4'd8,  8'h00, 4'h2, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_LOAD,   8'd127, 4'd0,  8'hFF, 4'h0, 4'h0, 1'b0}, 1'b0, 24'h000000},
    '{'{OP_RENDER, 8'd127, 4'd0,  8'h00, 4'hF, 4'h8, 1'b1}, 1'b1, 24'hFFFFFF}
  };

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Expand a colour code: each set channel bit takes the bright or normal level
  function automatic logic [23:0] palette_rgb(logic [3:0] code);
    logic [7:0] lvl;
    lvl = code[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
    return {{8{code[2]}} & lvl, {8{code[1]}} & lvl, {8{code[0]}} & lvl};
  endfunction

  // Apply one accepted transaction to the font copy, or queue the pixels it draws
  function automatic void apply_transaction(glyph_item_t it, bit solid, logic [23:0] solid_rgb);
    int unsigned addr;
    bit          in_cell;
    bit          grey;
    logic [7:0]  pattern;
    pixel_t      px;
    in_cell = (it.code < GLYPH_COUNT) && (it.line < GLYPH_LINES);
    addr    = int'(it.code) * GLYPH_LINES + int'(it.line);
    if (it.op == OP_LOAD) begin
      if (in_cell) begin
        font_copy[addr] = it.bits;
        if (!cell_loaded[addr]) begin
          cell_loaded[addr] = 1'b1;
          loaded_cells.push_back(addr);
        end
      end
      return;
    end
    pattern = in_cell ? font_copy[addr] : 8'h00;
    grey    = it.cursor && (it.line < GLYPH_LINES) &&
              (int'(it.line) + CURSOR_HEIGHT >= GLYPH_LINES);
    for (int k = 0; k < GLYPH_COLUMNS; k++) begin
      if (solid)         px.rgb = solid_rgb;
      else if (grey)     px.rgb = CURSOR_GREY;
      else if (pattern[7 - k]) px.rgb = palette_rgb(it.fg);
      else               px.rgb = palette_rgb(it.bg);
      px.column = 3'(k);
      px.last   = (k == GLYPH_COLUMNS - 1);
      pending_pixels.push_back(px);
    end
  endfunction

  // Offer one transaction, idling first now and then, and hold it until accepted
  task automatic send_item(glyph_item_t it, bit solid, logic [23:0] solid_rgb);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= it.op;
    in_bus.char_code   <= it.code;
    in_bus.glyph_line  <= it.line;
    in_bus.font_bits   <= it.bits;
    in_bus.fg_code     <= it.fg;
    in_bus.bg_code     <= it.bg;
    in_bus.cursor_cell <= it.cursor;
    do @(posedge clk_i); while (!in_bus.ready);
    apply_transaction(it, solid, solid_rgb);
  endtask

  // Random transaction: mostly loads and renders of loaded cells, some blank cells
  function automatic glyph_item_t random_item();
    glyph_item_t it;
    int unsigned pick;
    int unsigned addr;
    pick      = $urandom_range(0, 99);
    it.bits   = 8'($urandom);
    it.fg     = 4'($urandom);
    it.bg     = 4'($urandom);
    it.cursor = 1'($urandom);
    it.line   = 4'($urandom);
    if (pick < 35) begin
      it.op   = OP_LOAD;
      it.code = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(0, 127));
    end else if (pick < 50) begin
      it.op   = OP_RENDER;
      it.code = 8'($urandom_range(128, 255));
    end else begin
      it.op   = OP_RENDER;
      addr    = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
      it.code = 8'(addr / GLYPH_LINES);
      it.line = 4'(addr % GLYPH_LINES);
    end
    return it;
  endfunction

  // Pixel sink: check each transaction, then choose ready for the next cycle
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    pixel_t      got;
    pixel_t      want;
    hold_left = 0;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.pixel_rgb, out_bus.pixel_column, out_bus.last_pixel};
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected pixel rgb=%06h column=%0d last=%0b",
                   $time, got.rgb, got.column, got.last);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: pixel mismatch expected rgb=%06h column=%0d last=%0b,",
                     $time, want.rgb, want.column, want.last,
                     " got rgb=%06h column=%0d last=%0b",
                     got.rgb, got.column, got.last);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        // Long hold-off so the block backs up and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    mismatch_count = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.operation   <= OP_LOAD;
    in_bus.char_code   <= '0;
    in_bus.glyph_line  <= '0;
    in_bus.font_bits   <= '0;
    in_bus.fg_code     <= '0;
    in_bus.bg_code     <= '0;
    in_bus.cursor_cell <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (glyph_table[i])
      send_item(glyph_table[i].item, glyph_table[i].solid, glyph_table[i].solid_rgb);

    // Random items, with one long sink hold-off and one calm stretch
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      hold_request = (n >= 10);
      calm         = (n >= 40) && (n < 70);
      send_item(random_item(), 1'b0, 24'h0);
    end
    calm = 1'b0;
    in_bus.valid <= 1'b0;

    // Drain
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/tgr_pkg.sv
rtl/tgr_in_if.sv
rtl/tgr_out_if.sv
rtl/tgr_front.sv
rtl/tgr_queue.sv
rtl/tgr_back.sv
rtl/text_glyph_row_renderer.sv
tb/sv/tb_text_glyph_row_renderer.sv
